>>> hw/rtl/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define CAU_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define CAU_ASSERT(lbl, clk, rstn, prop)
`define CAU_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

>>> hw/rtl/cau_pkg.sv
// Types, constants and saturation helper of the complex arithmetic unit.
package cau_pkg;

  localparam int W   = 32;
  localparam int FB  = 16;
  localparam int PW  = 2 * W;
  localparam int VW  = PW + 2;
  localparam int RW  = 3 * W;
  localparam int NST = W;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_CONJ = 4'd4,
    OP_MOD  = 4'd5,
    OP_EQ   = 4'd6,
    OP_ADDR = 4'd7,
    OP_SUBR = 4'd8,
    OP_MULR = 4'd9,
    OP_DIVR = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_LIN,
    CLS_MUL,
    CLS_DIV,
    CLS_MOD
  } cls_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  typedef struct packed {
    op_e          op;
    cls_e         cls;
    logic         dz;
    logic [W-1:0] ar;
    logic [W-1:0] ai;
    logic [W-1:0] br;
    logic [W-1:0] bi;
  } item_t;

  typedef struct packed {
    cls_e          cls;
    logic          dz;
    logic          eq;
    logic          shift;
    logic          re_neg;
    logic          im_neg;
    logic          re_big;
    logic          im_big;
    logic [RW-1:0] re_rem;
    logic [RW-1:0] im_rem;
    logic [W-1:0]  re_q;
    logic [W-1:0]  im_q;
    logic [PW-1:0] den;
    logic [PW-1:0] sq_n;
    logic [PW-1:0] sq_res;
  } stage_t;

  typedef struct packed {
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         eq;
    status_e      status;
  } res_t;

  typedef struct packed {
    logic [W-1:0] val;
    logic         ovf;
  } sat_t;

  function automatic sat_t sat_mag(input logic neg, input logic big,
                                   input logic [RW-1:0] mag);
    logic [RW-1:0] lim;
    sat_t          r;
    lim = (RW'(1) << (W - 1)) - RW'(!neg);
    r.ovf = 1'b0;
    if (big || (mag > lim)) begin
      r.ovf = 1'b1;
      r.val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r.val = neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/cau_front.sv
// Front end: accepts items and sorts them into operation classes.
module cau_front import cau_pkg::*; (
  input  logic         start,
  input  logic         full_i,
  input  logic [3:0]   operation_i,
  input  logic [W-1:0] a_real_i,
  input  logic [W-1:0] a_imag_i,
  input  logic [W-1:0] b_real_i,
  input  logic [W-1:0] b_imag_i,
  output logic         push_o,
  output item_t        item_o
);

  op_e  op;
  cls_e cls;
  logic dz;

  assign op     = op_e'(operation_i);
  assign push_o = start && !full_i;

  always_comb begin
    cls = CLS_NONE;
    dz  = 1'b0;
    case (op)
      OP_ADD, OP_SUB, OP_CONJ, OP_EQ, OP_ADDR, OP_SUBR: cls = CLS_LIN;
      OP_MUL, OP_MULR: cls = CLS_MUL;
      OP_MOD: cls = CLS_MOD;
      OP_DIV: begin
        dz  = (b_real_i == '0) && (b_imag_i == '0);
        cls = dz ? CLS_NONE : CLS_DIV;
      end
      OP_DIVR: begin
        dz  = (b_real_i == '0);
        cls = dz ? CLS_NONE : CLS_DIV;
      end
      default: cls = CLS_NONE;
    endcase
  end

  assign item_o = '{op: op, cls: cls, dz: dz, ar: a_real_i, ai: a_imag_i,
                    br: b_real_i, bi: b_imag_i};

endmodule

>>> hw/rtl/cau_fifo.sv
// Two-entry item queue between the front end and the execution pipeline.
module cau_fifo import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t data_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

>>> hw/rtl/cau_back.sv
// Execution pipeline: products, sums, radix-2 dividers, square root, saturation.
module cau_back import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  avail_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  valid_o,
  output res_t  res_o
);

  // Stage 1: products.
  logic signed [W-1:0]  ar, ai, br, bi, s4, s5;
  logic signed [PW-1:0] m_d [6];
  logic signed [PW-1:0] m_q [6];
  logic                 s1_vld_q;
  item_t                s1_q;

  assign pop_o = avail_i;
  assign ar = $signed(item_i.ar);
  assign ai = $signed(item_i.ai);
  assign br = $signed(item_i.br);
  assign bi = $signed(item_i.bi);
  assign s4 = (item_i.op == OP_MOD) ? ar : br;
  assign s5 = (item_i.op == OP_MOD) ? ai : bi;

  assign m_d[0] = PW'(ar) * PW'(br);
  assign m_d[1] = PW'(ai) * PW'(bi);
  assign m_d[2] = PW'(ar) * PW'(bi);
  assign m_d[3] = PW'(ai) * PW'(br);
  assign m_d[4] = PW'(s4) * PW'(s4);
  assign m_d[5] = PW'(s5) * PW'(s5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else s1_vld_q <= avail_i;
  end

  always_ff @(posedge clk_i) begin
    s1_q <= item_i;
    m_q  <= m_d;
  end

  // Stage 2: sums and numerators.
  logic signed [VW-1:0] xa, xai, xb, xbi;
  logic signed [VW-1:0] re_v_d, im_v_d, re_v_q, im_v_q;
  logic [PW-1:0]        brw, den_d, den_q, sqn_d, sqn_q;
  logic                 eq_d, shift_d, dneg_d, eq_q, shift_q, dneg_q, s2_vld_q, dz_q;
  cls_e                 cls_q;

  assign xa  = VW'($signed(s1_q.ar));
  assign xai = VW'($signed(s1_q.ai));
  assign xb  = VW'($signed(s1_q.br));
  assign xbi = VW'($signed(s1_q.bi));
  assign brw = PW'($signed(s1_q.br));

  always_comb begin
    re_v_d  = '0;
    im_v_d  = '0;
    den_d   = '0;
    sqn_d   = '0;
    eq_d    = 1'b0;
    shift_d = 1'b0;
    dneg_d  = 1'b0;
    case (s1_q.cls)
      CLS_LIN: begin
        case (s1_q.op)
          OP_ADD: begin
            re_v_d = xa + xb;
            im_v_d = xai + xbi;
          end
          OP_SUB: begin
            re_v_d = xa - xb;
            im_v_d = xai - xbi;
          end
          OP_CONJ: begin
            re_v_d = xa;
            im_v_d = -xai;
          end
          OP_ADDR: begin
            re_v_d = xa + xb;
            im_v_d = xai;
          end
          OP_SUBR: begin
            re_v_d = xa - xb;
            im_v_d = xai;
          end
          OP_EQ: eq_d = (s1_q.ar == s1_q.br) && (s1_q.ai == s1_q.bi);
          default: re_v_d = '0;
        endcase
      end
      CLS_MUL: begin
        shift_d = 1'b1;
        if (s1_q.op == OP_MUL) begin
          re_v_d = VW'(m_q[0]) - VW'(m_q[1]);
          im_v_d = VW'(m_q[2]) + VW'(m_q[3]);
        end else begin
          re_v_d = VW'(m_q[0]);
          im_v_d = VW'(m_q[3]);
        end
      end
      CLS_DIV: begin
        if (s1_q.op == OP_DIV) begin
          re_v_d = VW'(m_q[0]) + VW'(m_q[1]);
          im_v_d = VW'(m_q[3]) - VW'(m_q[2]);
          den_d  = $unsigned(m_q[4]) + $unsigned(m_q[5]);
        end else begin
          re_v_d = xa;
          im_v_d = xai;
          den_d  = brw[PW-1] ? (~brw + PW'(1)) : brw;
          dneg_d = brw[PW-1];
        end
      end
      CLS_MOD: sqn_d = $unsigned(m_q[4]) + $unsigned(m_q[5]);
      default: re_v_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    re_v_q  <= re_v_d;
    im_v_q  <= im_v_d;
    den_q   <= den_d;
    sqn_q   <= sqn_d;
    eq_q    <= eq_d;
    shift_q <= shift_d;
    dneg_q  <= dneg_d;
    cls_q   <= s1_q.cls;
    dz_q    <= s1_q.dz;
  end

  // Stage 3: magnitudes and divider setup.
  logic [VW-1:0] re_mag, im_mag;
  logic [RW-1:0] re_num, im_num, den_top;
  stage_t        st0_d;
  stage_t        st_q [NST+1];
  logic          vld_q [NST+1];

  assign re_mag  = re_v_q[VW-1] ? $unsigned(-re_v_q) : $unsigned(re_v_q);
  assign im_mag  = im_v_q[VW-1] ? $unsigned(-im_v_q) : $unsigned(im_v_q);
  assign re_num  = RW'(re_mag) << FB;
  assign im_num  = RW'(im_mag) << FB;
  assign den_top = RW'(den_q) << W;

  always_comb begin
    st0_d        = '0;
    st0_d.cls    = cls_q;
    st0_d.dz     = dz_q;
    st0_d.eq     = eq_q;
    st0_d.shift  = shift_q;
    st0_d.den    = den_q;
    st0_d.sq_n   = sqn_q;
    st0_d.re_neg = re_v_q[VW-1] ^ dneg_q;
    st0_d.im_neg = im_v_q[VW-1] ^ dneg_q;
    if (cls_q == CLS_DIV) begin
      st0_d.re_rem = re_num;
      st0_d.im_rem = im_num;
      st0_d.re_big = (re_num >= den_top);
      st0_d.im_big = (im_num >= den_top);
    end else begin
      st0_d.re_rem = RW'(re_mag);
      st0_d.im_rem = RW'(im_mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else vld_q[0] <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
  end

  // Quotient and root stages, one bit each.
  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam int K = W - 1 - g;
    stage_t        nx;
    logic [RW-1:0] dk;
    logic [PW-1:0] bitv, trial;

    assign dk    = RW'(st_q[g].den) << K;
    assign bitv  = PW'(1) << (PW - 2 - 2 * g);
    assign trial = st_q[g].sq_res + bitv;

    always_comb begin
      nx = st_q[g];
      if (st_q[g].cls == CLS_DIV) begin
        if (st_q[g].re_rem >= dk) begin
          nx.re_rem  = st_q[g].re_rem - dk;
          nx.re_q[K] = 1'b1;
        end
        if (st_q[g].im_rem >= dk) begin
          nx.im_rem  = st_q[g].im_rem - dk;
          nx.im_q[K] = 1'b1;
        end
      end
      if (st_q[g].sq_n >= trial) begin
        nx.sq_n   = st_q[g].sq_n - trial;
        nx.sq_res = (st_q[g].sq_res >> 1) + bitv;
      end else begin
        nx.sq_res = st_q[g].sq_res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[g+1] <= 1'b0;
      else vld_q[g+1] <= vld_q[g];
    end

    always_ff @(posedge clk_i) begin
      st_q[g+1] <= nx;
    end
  end

  // Final stage: saturation and status.
  stage_t fin;
  sat_t   sr, si;
  res_t   res_d, res_q;
  logic   valid_q;

  assign fin = st_q[NST];

  always_comb begin
    sr = '0;
    si = '0;
    case (fin.cls)
      CLS_DIV: begin
        sr = sat_mag(fin.re_neg, fin.re_big, RW'(fin.re_q));
        si = sat_mag(fin.im_neg, fin.im_big, RW'(fin.im_q));
      end
      CLS_MOD: sr = sat_mag(1'b0, 1'b0, RW'(fin.sq_res));
      CLS_LIN, CLS_MUL: begin
        sr = sat_mag(fin.re_neg, 1'b0, fin.shift ? (fin.re_rem >> FB) : fin.re_rem);
        si = sat_mag(fin.im_neg, 1'b0, fin.shift ? (fin.im_rem >> FB) : fin.im_rem);
      end
      default: sr = '0;
    endcase
    res_d.re     = sr.val;
    res_d.im     = si.val;
    res_d.eq     = fin.eq;
    res_d.status = fin.dz ? ST_DZ : ((sr.ovf || si.ovf) ? ST_OVF : ST_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= vld_q[NST];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hw/rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  command | start / busy        | operation_i, a_real_i, a_imag_i, b_real_i, b_imag_i
//  result  | valid_o (strobe)    | res_real_o, res_imag_o, is_equal_o, status_o
//
// One item is taken per cycle while busy is low; each result strobes on valid_o
// after the queue, product, sum, setup, divider/root and saturation stages.
// Reset clears the queue and all valid bits; no memory needs clearing.
// The result side never stalls, so busy rises only if the two-entry queue fills.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [3:0]   operation_i,
  input  logic [W-1:0] a_real_i,
  input  logic [W-1:0] a_imag_i,
  input  logic [W-1:0] b_real_i,
  input  logic [W-1:0] b_imag_i,
  output logic         valid_o,
  output logic [W-1:0] res_real_o,
  output logic [W-1:0] res_imag_o,
  output logic         is_equal_o,
  output logic [1:0]   status_o
);

  logic  push, full, empty, pop;
  item_t fr_item, q_item;
  res_t  res;

  cau_front u_front (
    .start       (start),
    .full_i      (full),
    .operation_i (operation_i),
    .a_real_i    (a_real_i),
    .a_imag_i    (a_imag_i),
    .b_real_i    (b_real_i),
    .b_imag_i    (b_imag_i),
    .push_o      (push),
    .item_o      (fr_item)
  );

  cau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (q_item)
  );

  cau_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!empty),
    .item_i  (q_item),
    .pop_o   (pop),
    .valid_o (valid_o),
    .res_o   (res)
  );

  assign busy       = full;
  assign res_real_o = res.re;
  assign res_imag_o = res.im;
  assign is_equal_o = res.eq;
  assign status_o   = res.status;

  `CAU_ASSERT(a_eq_clean, clk_i, rst_ni, is_equal_o |-> (res_real_o == '0) && (res_imag_o == '0) && (status_o == ST_OK))
  `CAU_ASSERT(a_dz_zero, clk_i, rst_ni, (valid_o && (status_o == ST_DZ)) |-> (res_real_o == '0) && (res_imag_o == '0))
  `CAU_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && full)

endmodule

>>> test/complex_arithmetic_unit_tb.sv
// Self-checking testbench of the complex arithmetic unit with directed and random items.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  status;
  } cplx_res_t;

  class result_board;
    cplx_res_t pending[$];
    int        mismatches;
    int        checked;

    static function logic [63:0] wide_isqrt(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    static function logic signed [31:0] clamp(logic signed [127:0] v, ref bit ovf);
      if (v > 128'sd2147483647) begin
        ovf = 1;
        return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
        ovf = 1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // Truncates toward zero, as the block does for products and quotients.
    static function logic signed [127:0] shr_trunc(logic signed [127:0] v);
      if (v < 0) return -((-v) >>> FB);
      return v >>> FB;
    endfunction

    static function logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                   logic signed [127:0] d);
      logic [127:0] q;
      logic         neg;
      neg = (n < 0) != (d < 0);
      q = ((n < 0 ? -n : n) << FB) / (d < 0 ? -d : d);
      return neg ? -$signed(q) : $signed(q);
    endfunction

    static function cplx_res_t compute(logic [3:0] op, logic signed [31:0] ar,
                                       logic signed [31:0] ai, logic signed [31:0] br,
                                       logic signed [31:0] bi);
      logic signed [127:0] re, im, den;
      cplx_res_t           r;
      bit                  ovf, dz;
      re = 0; im = 0; ovf = 0; dz = 0;
      r.eq = 0;
      case (op)
        OP_ADD: begin re = ar + 128'sd0 + br; im = ai + 128'sd0 + bi; end
        OP_SUB: begin re = ar + 128'sd0 - br; im = ai + 128'sd0 - bi; end
        OP_MUL: begin
          re = shr_trunc(128'(ar) * br - 128'(ai) * bi);
          im = shr_trunc(128'(ar) * bi + 128'(ai) * br);
        end
        OP_DIV: begin
          if (br == 0 && bi == 0) begin
            dz = 1;
          end else begin
            den = 128'(br) * br + 128'(bi) * bi;
            re = div_trunc(128'(ar) * br + 128'(ai) * bi, den);
            im = div_trunc(128'(ai) * br - 128'(ar) * bi, den);
          end
        end
        OP_CONJ: begin re = ar; im = -128'(ai); end
        OP_MOD: re = wide_isqrt(64'(128'(ar) * ar + 128'(ai) * ai));
        OP_EQ: r.eq = (ar == br) && (ai == bi);
        OP_ADDR: begin re = ar + 128'sd0 + br; im = ai; end
        OP_SUBR: begin re = ar + 128'sd0 - br; im = ai; end
        OP_MULR: begin re = shr_trunc(128'(ar) * br); im = shr_trunc(128'(ai) * br); end
        OP_DIVR: begin
          if (br == 0) dz = 1;
          else begin re = div_trunc(ar, br); im = div_trunc(ai, br); end
        end
        default: ;
      endcase
      r.re = clamp(re, ovf);
      r.im = clamp(im, ovf);
      r.status = dz ? ST_DZ : (ovf ? ST_OVF : ST_OK);
      return r;
    endfunction

    function void note_item(logic [3:0] op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
      pending.push_back(compute(op, ar, ai, br, bi));
    endfunction

    function void check_result(logic [31:0] re, logic [31:0] im, logic eq, logic [1:0] st);
      cplx_res_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result re=%h im=%h", re, im);
        return;
      end
      e = pending.pop_front();
      if (e.re !== re || e.im !== im || e.eq !== eq || e.status !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected re=%h im=%h eq=%b st=%0d, got re=%h im=%h eq=%b st=%0d",
                   e.re, e.im, e.eq, e.status, re, im, eq, st);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [3:0]  operation_i = 0;
  logic [31:0] a_real_i = 0, a_imag_i = 0, b_real_i = 0, b_imag_i = 0;
  logic        valid_o;
  logic [31:0] res_real_o, res_imag_o;
  logic        is_equal_o;
  logic [1:0]  status_o;

  result_board board = new();
  int          cycles = 0;
  int          sent;
  bit          timed_out;

  complex_arithmetic_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .a_real_i, .a_imag_i,
    .b_real_i, .b_imag_i, .valid_o, .res_real_o, .res_imag_o, .is_equal_o, .status_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o) board.check_result(res_real_o, res_imag_o, is_equal_o, status_o);
    if (rst_ni && start && !busy)
      board.note_item(operation_i, a_real_i, a_imag_i, b_real_i, b_imag_i);
  end

  initial begin
    timed_out = 0;
    wait (cycles > 200000);
    timed_out = 1;
  end

  task automatic send_item(logic [3:0] op, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi, bit keep);
    start <= 1;
    operation_i <= op;
    a_real_i <= ar; a_imag_i <= ai; b_real_i <= br; b_imag_i <= bi;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    if (!keep) start <= 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
      2: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7fffffff;
      3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      default: return 32'($signed(20'($urandom()))) ;
    endcase
  endfunction

  initial begin
    logic [3:0]  op;
    logic [31:0] ar, ai, br, bi;
    int          burst;
    sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff, 1);
    send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff, 1);
    send_item(OP_MUL, 32'h00020000, 32'h00030000, 32'hffff0000, 32'h00008000, 1);
    send_item(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1);
    send_item(OP_DIV, 32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000, 1);
    send_item(OP_DIV, 32'h00050000, 32'h00050000, 32'h0, 32'h0, 1);
    send_item(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0, 1);
    send_item(OP_CONJ, 32'h12345678, 32'h80000000, 32'h0, 32'h0, 1);
    send_item(OP_CONJ, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1);
    send_item(OP_MOD, 32'h00030000, 32'h00040000, 32'h0, 32'h0, 1);
    send_item(OP_MOD, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 1);
    send_item(OP_EQ, 32'h11112222, 32'h33334444, 32'h11112222, 32'h33334444, 1);
    send_item(OP_EQ, 32'h11112222, 32'h33334444, 32'h11112222, 32'h33334445, 1);
    send_item(OP_ADDR, 32'h7fff0000, 32'h80000000, 32'h7fff0000, 32'hdeadbeef, 1);
    send_item(OP_SUBR, 32'h80000000, 32'h7fffffff, 32'h00010000, 32'h0, 1);
    send_item(OP_MULR, 32'hfffe0000, 32'h00018000, 32'hfffd0000, 32'h12345678, 1);
    send_item(OP_DIVR, 32'h00070000, 32'hfff90000, 32'h00020000, 32'h0, 1);
    send_item(OP_DIVR, 32'h00070000, 32'h00010000, 32'h0, 32'hffffffff, 1);
    send_item(OP_DIVR, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0, 1);
    send_item(4'd11, 32'h1, 32'h2, 32'h3, 32'h4, 1);
    send_item(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
    // Hold off until the pipeline has drained.
    while (board.pending.size() != 0 && !timed_out) @(posedge clk_i);
    while (sent < 520 && !timed_out) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
        ar = pick_value(); ai = pick_value(); br = pick_value(); bi = pick_value();
        if ($urandom_range(0, 7) == 0) begin br = ar; bi = ai; end
        if ($urandom_range(0, 15) == 0) begin br = 0; bi = $urandom_range(0, 1) ? 0 : bi; end
        send_item(op, ar, ai, br, bi, k != burst - 1);
      end
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk_i);
    end
    while (board.pending.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items over all opcodes, checked %0d results with %0d mismatches.",
             sent, board.checked, board.mismatches);
    if (timed_out) $display("simulation failed");
    else if (board.mismatches == 0 && board.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    wait (timed_out);
    @(posedge clk_i);
    $display("Run stopped at the cycle limit.");
    $display("simulation failed");
    $finish;
  end
endmodule
